[src/lnpt_pkg.sv]
package lnpt_pkg;

    localparam int NOTE_COUNT = 128;
    localparam int NOTE_W     = 7;
    localparam int RANK_W     = 8;
    localparam int CNT_W      = $clog2(NOTE_COUNT + 1);
    localparam logic [NOTE_W-1:0] RESET_NOTE = NOTE_W'(69);

    localparam logic ACT_ON  = 1'b0;
    localparam logic ACT_OFF = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_UPDATE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // Word handed from one cell to the next along the chain.
    typedef struct packed {
        logic [RANK_W-1:0] old_rank;
        logic              found;
        logic [RANK_W-1:0] best_rank;
        logic [NOTE_W-1:0] best_idx;
    } t_link;

    // Update broadcast to every cell for one cycle.
    typedef struct packed {
        logic              upd;
        logic              dec_en;
        logic [RANK_W-1:0] old_rank;
        logic [RANK_W-1:0] set_val;
        logic [NOTE_W-1:0] note;
    } t_cmd;

endpackage

[src/lnpt_cell.sv]
module lnpt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lnpt_pkg::NOTE_W-1:0] i_idx,
    input  lnpt_pkg::t_cmd            i_cmd,
    input  lnpt_pkg::t_link           i_link,
    output lnpt_pkg::t_link           o_link
);

    logic [lnpt_pkg::RANK_W-1:0] r_rank;
    logic [lnpt_pkg::RANK_W-1:0] n_rank;
    lnpt_pkg::t_link             r_link;
    lnpt_pkg::t_link             n_link;
    logic                        hit;

    assign hit = (i_idx == i_cmd.note);

    always_comb begin
        n_rank = r_rank;
        if (i_cmd.upd) begin
            if (hit) begin
                n_rank = i_cmd.set_val;
            end else if (i_cmd.dec_en && (r_rank > i_cmd.old_rank)) begin
                n_rank = r_rank - 1'b1;
            end
        end
    end

    always_comb begin
        n_link = i_link;
        if (hit) begin
            n_link.old_rank = i_link.old_rank | r_rank;
        end
        // Ranks of held notes are unique, so a strict compare is enough.
        if ((r_rank != '0) && (!i_link.found || (r_rank > i_link.best_rank))) begin
            n_link.found     = 1'b1;
            n_link.best_rank = r_rank;
            n_link.best_idx  = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else begin
            r_rank <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
    end

    assign o_link = r_link;

endmodule

[src/last_note_priority_tracker.sv]
// Channel  Direction  tdata fields (low bit up)
// s        in         action[0], note[7:1]
// m        out        sounding_note[6:0], gate[7], held_count[15:8]
//
// One event at a time: every in-range event makes one pass along the cell
// chain to fetch the old rank, and a note-off makes a second pass to find
// the newest held note. An out-of-range note skips the chain and reports
// the held state unchanged. Reset clears every rank at once.
// A stalled result holds; the next event is taken once the block is idle.
module last_note_priority_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // action, note
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // sounding_note, gate, held_count
);

    localparam int N = lnpt_pkg::NOTE_COUNT;

    lnpt_pkg::t_state                r_state, n_state;
    logic [lnpt_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_action, n_action;
    logic [lnpt_pkg::NOTE_W-1:0]     r_note, n_note;
    logic [lnpt_pkg::RANK_W-1:0]     r_old, n_old;
    logic [lnpt_pkg::RANK_W-1:0]     r_held, n_held;
    logic [lnpt_pkg::NOTE_W-1:0]     r_cur, n_cur;
    logic                            r_gate, n_gate;
    logic                            r_out_valid, n_out_valid;
    logic [15:0]                     r_out_data, n_out_data;

    lnpt_pkg::t_cmd                  cmd;
    lnpt_pkg::t_link                 links [N+1];
    logic                            in_acc;
    logic                            in_range;
    logic                            cnt_done;

    assign links[0] = '0;

    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        lnpt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (lnpt_pkg::NOTE_W'(gi)),
            .i_cmd   (cmd),
            .i_link  (links[gi]),
            .o_link  (links[gi+1])
        );
    end

    assign o_s_tready = (r_state == lnpt_pkg::ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign in_range   = ({1'b0, i_s_tdata[7:1]} < (lnpt_pkg::NOTE_W + 1)'(N));
    assign cnt_done   = (r_cnt == lnpt_pkg::CNT_W'(N));

    always_comb begin
        cmd          = '0;
        cmd.note     = r_note;
        cmd.old_rank = r_old;
        cmd.dec_en   = (r_old != '0);
        if (r_state == lnpt_pkg::ST_UPDATE) begin
            cmd.upd = 1'b1;
        end
        if (r_action == lnpt_pkg::ACT_OFF) begin
            cmd.set_val = '0;
        end else if (r_old != '0) begin
            cmd.set_val = r_held;
        end else if (r_held < lnpt_pkg::RANK_W'(N)) begin
            cmd.set_val = r_held + 1'b1;
        end else begin
            cmd.set_val = r_held;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_action    = r_action;
        n_note      = r_note;
        n_old       = r_old;
        n_held      = r_held;
        n_cur       = r_cur;
        n_gate      = r_gate;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            lnpt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_action = i_s_tdata[0];
                    n_note   = i_s_tdata[7:1];
                    n_cnt    = '0;
                    n_state  = in_range ? lnpt_pkg::ST_GATHER : lnpt_pkg::ST_DONE;
                end
            end
            lnpt_pkg::ST_GATHER: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_done) begin
                    n_old   = links[N].old_rank;
                    n_state = lnpt_pkg::ST_UPDATE;
                end
            end
            lnpt_pkg::ST_UPDATE: begin
                n_cnt = '0;
                if (r_action == lnpt_pkg::ACT_ON) begin
                    n_held  = cmd.set_val;
                    n_cur   = r_note;
                    n_gate  = 1'b1;
                    n_state = lnpt_pkg::ST_DONE;
                end else begin
                    if ((r_old != '0) && (r_held != '0)) begin
                        n_held = r_held - 1'b1;
                    end
                    n_state = lnpt_pkg::ST_SEARCH;
                end
            end
            lnpt_pkg::ST_SEARCH: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_done) begin
                    if (links[N].found) begin
                        n_cur = links[N].best_idx;
                    end else begin
                        n_gate = 1'b0;
                    end
                    n_state = lnpt_pkg::ST_DONE;
                end
            end
            lnpt_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_held, r_gate, r_cur};
                    n_state     = lnpt_pkg::ST_IDLE;
                end
            end
            default: n_state = lnpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lnpt_pkg::ST_IDLE;
            r_held      <= '0;
            r_cur       <= lnpt_pkg::RESET_NOTE;
            r_gate      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_cur       <= n_cur;
            r_gate      <= n_gate;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_action   <= n_action;
        r_note     <= n_note;
        r_old      <= n_old;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[src/lnpt_checker.sv]
module lnpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while stalled");

    // The gate is high exactly when some note is held.
    a_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7] == (o_m_tdata[15:8] != 8'd0)))
        else $error("gate disagrees with held count");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:8] <= 8'd128))
        else $error("held count out of range");

    // Events are handled one at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while busy");

endmodule

bind last_note_priority_tracker lnpt_checker u_lnpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
